### rtl/tltoc_pkg.sv
package tltoc_pkg;

  localparam int PREFIX_MAX   = 8;
  localparam int POS_BITS_DEF = 24;
  localparam int UNIT_W       = 16;
  localparam int PLACE_W      = 24;
  localparam int PFX_W        = 64;
  localparam int LEN_W        = 4;
  localparam int CNT_W        = 4;
  localparam int FL_IDX_W     = 3;
  localparam int TAIL_N       = 4;
  localparam int TAIL_IDX_W   = 2;
  localparam int TAIL_CNT_W   = 3;
  localparam int CFG_IDX_W    = 2;

  localparam logic [UNIT_W-1:0] CH_LF = 16'd10;
  localparam logic [UNIT_W-1:0] CH_CR = 16'd13;

  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_ENTRY,
    KIND_ENTRY_END,
    KIND_END_TEXT
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOC_ENABLE,
    REG_DELETE_LINES,
    REG_PREFIX_LEN,
    REG_PREFIX_CHARS
  } cfg_reg_t;

  typedef struct packed {
    kind_t              kind;
    logic [UNIT_W-1:0]  unit;
    logic [PLACE_W-1:0] place;
  } res_t;

  function automatic logic [UNIT_W-1:0] prefix_unit(input logic [PFX_W-1:0]    chars,
                                                    input logic [FL_IDX_W-1:0] idx);
    return UNIT_W'(chars[8*int'(idx) +: 8]);
  endfunction

endpackage

### rtl/text_line_toc_extractor.sv
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   code_unit, end_of_text
// result    out        out_valid/out_stall kind, unit_out, line_place, last
// config    in         cfg_we              cfg_index, cfg_data
//
// One word of input is decoded in the cycle it is taken and yields 0 to 11 result
// words; these are queued and move into the result register whenever it is free. The
// result register sends one word a cycle while out_stall is low, so a word with at most
// one result follows the previous one back to back; a word with several results stalls
// the input until only its last result is queued and the result register is free.
// rst is synchronous; it restores the register defaults and the start-of-text state.
// out_stall holds the result register; in_stall rises while results queue up behind it.
module text_line_toc_extractor #(
  parameter int POS_BITS = tltoc_pkg::POS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tltoc_pkg::UNIT_W-1:0]         code_unit,
  input  logic                                 end_of_text,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tltoc_pkg::kind_t                     kind,
  output logic [tltoc_pkg::UNIT_W-1:0]         unit_out,
  output logic [tltoc_pkg::PLACE_W-1:0]        line_place,
  output logic                                 last,
  input  logic                                 cfg_we,
  input  logic [tltoc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tltoc_pkg::PFX_W-1:0]          cfg_data
);
  import tltoc_pkg::*;

  typedef enum logic [1:0] {PH_MATCH, PH_ENTRY, PH_BODY, PH_AFTER} phase_t;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic               toc_enable;
  logic               delete_toc_lines;
  logic [LEN_W-1:0]   prefix_length;
  logic [PFX_W-1:0]   prefix_chars;

  logic               prev_raw_cr;
  phase_t             phase;
  logic [CNT_W-1:0]   matched_count;
  logic [POS_BITS-1:0] body_position;
  logic [POS_BITS-1:0] line_start_pos;

  logic [CNT_W-1:0]      fl_cnt;
  logic [FL_IDX_W-1:0]   fl_idx;
  res_t                  tail [TAIL_N];
  logic [TAIL_CNT_W-1:0] tl_cnt;

  logic                  prev_raw_cr_next;
  phase_t                phase_next;
  logic [CNT_W-1:0]      matched_count_next;
  logic [POS_BITS-1:0]   body_position_next;
  logic [POS_BITS-1:0]   line_start_pos_next;
  logic [CNT_W-1:0]      fl_cnt_next;
  res_t                  tail_next [TAIL_N];
  logic [TAIL_CNT_W-1:0] tl_cnt_next;

  logic [UNIT_W-1:0]   u;
  logic                drop_lf;
  logic [LEN_W-1:0]    eff_len;
  logic                ent_unit;
  logic                ent_end;
  logic                body_en;
  logic                new_line;
  logic                after_pfx;
  logic [CNT_W-1:0]    nb;
  logic [POS_BITS:0]   pos_sum;
  logic [POS_BITS-1:0] pos_sat;
  res_t                cand [TAIL_N];
  logic [TAIL_N-1:0]   cand_en;

  logic [CNT_W-1:0] remain;
  logic             out_free;
  logic             accept;
  logic             move;
  res_t             head;

  assign remain   = fl_cnt + CNT_W'(tl_cnt);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((remain == CNT_W'(0)) || ((remain == CNT_W'(1)) && out_free));
  assign accept   = in_valid && !in_stall;
  assign move     = out_free && (remain != CNT_W'(0));

  always_comb begin
    if (fl_cnt != CNT_W'(0)) begin
      head.kind  = KIND_BODY;
      head.unit  = prefix_unit(prefix_chars, fl_idx);
      head.place = '0;
    end else begin
      head = tail[0];
    end
  end

  assign u       = (code_unit == CH_LF) ? CH_CR : code_unit;
  assign drop_lf = (code_unit == CH_LF) && prev_raw_cr;
  assign eff_len = (prefix_length > LEN_W'(PREFIX_MAX)) ? LEN_W'(PREFIX_MAX) : prefix_length;

  always_comb begin
    phase_next         = phase;
    matched_count_next = matched_count;
    fl_cnt_next        = '0;
    ent_unit           = 1'b0;
    ent_end            = 1'b0;
    body_en            = 1'b0;
    new_line           = 1'b0;
    after_pfx          = 1'b0;

    if (!drop_lf) begin
      unique case (phase)
        PH_ENTRY: begin
          body_en = !delete_toc_lines;
          if (u == CH_CR) begin
            ent_end  = 1'b1;
            new_line = 1'b1;
          end else begin
            ent_unit = 1'b1;
          end
        end
        PH_BODY: begin
          body_en  = 1'b1;
          new_line = (u == CH_CR);
        end
        default: begin
          if (!toc_enable) begin
            fl_cnt_next        = matched_count_next;
            matched_count_next = '0;
            body_en            = 1'b1;
            if (u == CH_CR) begin
              new_line = 1'b1;
            end else begin
              phase_next = PH_BODY;
            end
          end else begin
            after_pfx = (phase == PH_AFTER);
            if (phase == PH_MATCH) begin
              if (matched_count >= eff_len) begin
                after_pfx  = 1'b1;
                phase_next = PH_AFTER;
                if (!delete_toc_lines) begin
                  fl_cnt_next        = matched_count_next;
                  matched_count_next = '0;
                end
              end else if (u == CH_CR) begin
                fl_cnt_next        = matched_count_next;
                matched_count_next = '0;
                body_en            = 1'b1;
                new_line           = 1'b1;
              end else if (u == prefix_unit(prefix_chars, matched_count[FL_IDX_W-1:0])) begin
                matched_count_next = matched_count + CNT_W'(1);
                if (matched_count_next >= eff_len) begin
                  phase_next = PH_AFTER;
                  if (!delete_toc_lines) begin
                    fl_cnt_next        = matched_count_next;
                    matched_count_next = '0;
                  end
                end
              end else begin
                fl_cnt_next        = matched_count_next;
                matched_count_next = '0;
                body_en            = 1'b1;
                phase_next         = PH_BODY;
              end
            end
            if (after_pfx) begin
              if (u == CH_CR) begin
                fl_cnt_next        = fl_cnt_next + matched_count_next;
                matched_count_next = '0;
                body_en            = 1'b1;
                new_line           = 1'b1;
              end else begin
                matched_count_next = '0;
                phase_next         = PH_ENTRY;
                ent_unit           = 1'b1;
                body_en            = !delete_toc_lines;
              end
            end
          end
        end
      endcase
    end

    nb      = fl_cnt_next + CNT_W'(body_en);
    pos_sum = {1'b0, body_position} + (POS_BITS+1)'(nb);
    pos_sat = pos_sum[POS_BITS] ? POS_MAX : pos_sum[POS_BITS-1:0];

    body_position_next  = pos_sat;
    line_start_pos_next = line_start_pos;
    prev_raw_cr_next    = drop_lf ? 1'b0 : (code_unit == CH_CR);
    if (new_line) begin
      phase_next          = PH_MATCH;
      matched_count_next  = '0;
      line_start_pos_next = pos_sat;
    end

    cand[0].kind  = ent_end ? KIND_ENTRY_END : KIND_ENTRY;
    cand[0].unit  = ent_end ? '0 : u;
    cand[0].place = ent_end ? PLACE_W'(line_start_pos) : '0;
    cand[1].kind  = KIND_BODY;
    cand[1].unit  = u;
    cand[1].place = '0;
    cand[2].kind  = KIND_ENTRY_END;
    cand[2].unit  = '0;
    cand[2].place = PLACE_W'(line_start_pos);
    cand[3].kind  = KIND_END_TEXT;
    cand[3].unit  = '0;
    cand[3].place = '0;
    cand_en = {end_of_text, end_of_text && (phase_next == PH_ENTRY), body_en,
               ent_unit || ent_end};

    if (end_of_text) begin
      if (phase_next != PH_ENTRY) begin
        fl_cnt_next = fl_cnt_next + matched_count_next;
      end
      prev_raw_cr_next    = 1'b0;
      body_position_next  = '0;
      line_start_pos_next = '0;
      phase_next          = PH_MATCH;
      matched_count_next  = '0;
    end

    for (int i = 0; i < TAIL_N; i++) begin
      tail_next[i] = cand[i];
    end
    tl_cnt_next = '0;
    for (int i = 0; i < TAIL_N; i++) begin
      if (cand_en[i]) begin
        tail_next[tl_cnt_next[TAIL_IDX_W-1:0]] = cand[i];
        tl_cnt_next = tl_cnt_next + TAIL_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      toc_enable       <= 1'b0;
      delete_toc_lines <= 1'b1;
      prefix_length    <= '0;
      prefix_chars     <= '0;
      prev_raw_cr      <= 1'b0;
      phase            <= PH_MATCH;
      matched_count    <= '0;
      body_position    <= '0;
      line_start_pos   <= '0;
      fl_cnt           <= '0;
      fl_idx           <= '0;
      tl_cnt           <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TOC_ENABLE:   toc_enable       <= cfg_data[0];
          REG_DELETE_LINES: delete_toc_lines <= cfg_data[0];
          REG_PREFIX_LEN:   prefix_length    <= cfg_data[LEN_W-1:0];
          REG_PREFIX_CHARS: prefix_chars     <= cfg_data;
          default:          prefix_chars     <= prefix_chars;
        endcase
      end

      if (move) begin
        out_valid  <= 1'b1;
        kind       <= head.kind;
        unit_out   <= head.unit;
        line_place <= head.place;
        last       <= (remain == CNT_W'(1));
      end else if (out_free) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        prev_raw_cr    <= prev_raw_cr_next;
        phase          <= phase_next;
        matched_count  <= matched_count_next;
        body_position  <= body_position_next;
        line_start_pos <= line_start_pos_next;
        fl_cnt         <= fl_cnt_next;
        fl_idx         <= '0;
        tl_cnt         <= tl_cnt_next;
        for (int i = 0; i < TAIL_N; i++) begin
          tail[i] <= tail_next[i];
        end
      end else if (move) begin
        if (fl_cnt != CNT_W'(0)) begin
          fl_cnt <= fl_cnt - CNT_W'(1);
          fl_idx <= fl_idx + FL_IDX_W'(1);
        end else begin
          for (int i = 0; i < TAIL_N - 1; i++) begin
            tail[i] <= tail[i+1];
          end
          tl_cnt <= tl_cnt - TAIL_CNT_W'(1);
        end
      end
    end
  end

  a_line_start_order: assert property (@(posedge clk) disable iff (rst)
    line_start_pos <= body_position)
    else $error("line start beyond body position");

  a_entry_holds_none: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ENTRY |-> matched_count == CNT_W'(0))
    else $error("held units inside an entry line");

  a_end_text_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_END_TEXT) |-> last)
    else $error("end of text word not marked last");

  a_eot_queues: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> remain != CNT_W'(0))
    else $error("end of text word produced no result");

endmodule

### verif/toc_stream_checker.sv
module toc_stream_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [tltoc_pkg::UNIT_W-1:0]        code_unit,
  input  logic                                end_of_text,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  tltoc_pkg::kind_t                    kind,
  input  logic [tltoc_pkg::UNIT_W-1:0]        unit_out,
  input  logic [tltoc_pkg::PLACE_W-1:0]       line_place,
  input  logic                                last,
  input  logic                                cfg_we,
  input  logic [tltoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tltoc_pkg::PFX_W-1:0]         cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tltoc_pkg::*;

  typedef enum logic [1:0] {
    LINE_MATCH,
    LINE_ENTRY,
    LINE_BODY,
    LINE_AFTER
  } line_phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [UNIT_W-1:0]  unit;
    logic [PLACE_W-1:0] place;
    logic               last;
  } toc_word_t;

  logic               toc_en;
  logic               del_lines;
  logic [LEN_W-1:0]   pfx_len;
  logic [PFX_W-1:0]   pfx_chars;

  logic               prev_cr;
  line_phase_t        phase;
  int unsigned        held;
  logic [PLACE_W-1:0] body_pos;
  logic [PLACE_W-1:0] line_start;

  toc_word_t          step_words[$];
  toc_word_t          expected_words[$];

  function automatic void emit(kind_t k, logic [UNIT_W-1:0] u, logic [PLACE_W-1:0] p);
    step_words.push_back('{kind: k, unit: u, place: p, last: 1'b0});
  endfunction

  function automatic void body_unit(logic [UNIT_W-1:0] u);
    emit(KIND_BODY, u, '0);
    if (body_pos != '1) body_pos++;
  endfunction

  function automatic void release_held();
    for (int i = 0; i < held; i++) begin
      body_unit({8'h00, pfx_chars[8*i +: 8]});
    end
    held = 0;
  endfunction

  function automatic void begin_line();
    phase = LINE_MATCH;
    held = 0;
    line_start = body_pos;
  endfunction

  function automatic int unsigned active_len();
    return (pfx_len > PREFIX_MAX) ? PREFIX_MAX : pfx_len;
  endfunction

  function automatic void close_prefix();
    phase = LINE_AFTER;
    if (!del_lines) release_held();
  endfunction

  function automatic void take_unit(logic [UNIT_W-1:0] u);
    if (phase == LINE_ENTRY) begin
      if (u == CH_CR) begin
        emit(KIND_ENTRY_END, '0, line_start);
        if (!del_lines) body_unit(u);
        begin_line();
      end else begin
        emit(KIND_ENTRY, u, '0);
        if (!del_lines) body_unit(u);
      end
      return;
    end
    if (phase == LINE_BODY) begin
      body_unit(u);
      if (u == CH_CR) begin_line();
      return;
    end
    if (!toc_en) begin
      release_held();
      body_unit(u);
      if (u == CH_CR) begin_line();
      else phase = LINE_BODY;
      return;
    end
    if (phase == LINE_MATCH) begin
      if (held >= active_len()) begin
        close_prefix();
      end else begin
        if (u == CH_CR) begin
          release_held();
          body_unit(u);
          begin_line();
        end else if (u == {8'h00, pfx_chars[8*held +: 8]}) begin
          held++;
          if (held >= active_len()) close_prefix();
        end else begin
          release_held();
          body_unit(u);
          phase = LINE_BODY;
        end
        return;
      end
    end
    if (u == CH_CR) begin
      release_held();
      body_unit(u);
      begin_line();
    end else begin
      held = 0;
      phase = LINE_ENTRY;
      emit(KIND_ENTRY, u, '0);
      if (!del_lines) body_unit(u);
    end
  endfunction

  function automatic void predict_entries(logic [UNIT_W-1:0] u, logic eot);
    toc_word_t w;
    step_words.delete();
    if (u == CH_LF && prev_cr) begin
      prev_cr = 1'b0;
    end else begin
      prev_cr = (u == CH_CR);
      take_unit((u == CH_LF) ? CH_CR : u);
    end
    if (eot) begin
      if (phase == LINE_ENTRY) emit(KIND_ENTRY_END, '0, line_start);
      else release_held();
      emit(KIND_END_TEXT, '0, '0);
      prev_cr = 1'b0;
      body_pos = '0;
      begin_line();
    end
    foreach (step_words[i]) begin
      w = step_words[i];
      w.last = (i == step_words.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void clear_state();
    toc_en = 1'b0;
    del_lines = 1'b1;
    pfx_len = '0;
    pfx_chars = '0;
    prev_cr = 1'b0;
    body_pos = '0;
    begin_line();
    expected_words.delete();
  endfunction

  function automatic void check_word();
    toc_word_t w;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected word kind %0d unit %h place %h last %b",
                 $time, kind, unit_out, line_place, last);
      return;
    end
    w = expected_words.pop_front();
    if (kind !== w.kind || unit_out !== w.unit || line_place !== w.place ||
        last !== w.last) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"%0t: mismatch, expected kind %0d unit %h place %h last %b, ",
                  "got kind %0d unit %h place %h last %b"},
                 $time, w.kind, w.unit, w.place, w.last, kind, unit_out, line_place, last);
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_TOC_ENABLE:   toc_en = cfg_data[0];
          REG_DELETE_LINES: del_lines = cfg_data[0];
          REG_PREFIX_LEN:   pfx_len = cfg_data[LEN_W-1:0];
          REG_PREFIX_CHARS: pfx_chars = cfg_data;
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) predict_entries(code_unit, end_of_text);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_word();
    end
    pending = expected_words.size();
  end

endmodule

### verif/text_line_toc_extractor_test.sv
module text_line_toc_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tltoc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [UNIT_W-1:0]   code_unit;
  logic                end_of_text;
  logic                out_valid;
  logic                out_stall;
  kind_t               kind;
  logic [UNIT_W-1:0]   unit_out;
  logic [PLACE_W-1:0]  line_place;
  logic                last;
  logic                cfg_we;
  cfg_reg_t            cfg_index;
  logic [PFX_W-1:0]    cfg_data;

  int                  fail_count;
  int                  pending;
  int                  items_sent;
  int                  burst_left;
  bit                  steady;
  int                  cycle_count;
  int unsigned         stall_tick;

  text_line_toc_extractor u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_unit   (code_unit),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .unit_out    (unit_out),
    .line_place  (line_place),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  toc_stream_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_unit   (code_unit),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .unit_out    (unit_out),
    .line_place  (line_place),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    stall_tick++;
    case (stall_tick[7:6])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 99) < 30);
      2'd2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  task automatic send_word(input logic [UNIT_W-1:0] u, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    code_unit <= u;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_one(input cfg_reg_t idx, input logic [PFX_W-1:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_regs(input logic toc, input logic del, input logic [LEN_W-1:0] len,
                            input logic [PFX_W-1:0] chars);
    write_one(REG_TOC_ENABLE, PFX_W'(toc));
    write_one(REG_DELETE_LINES, PFX_W'(del));
    write_one(REG_PREFIX_LEN, PFX_W'(len));
    write_one(REG_PREFIX_CHARS, chars);
  endtask

  // prefix (full, partial or broken), some content, then a line end or end of text
  task automatic random_line(input int plen, input logic [PFX_W-1:0] pchars);
    int shape;
    int k;
    int n;
    logic [UNIT_W-1:0] u;
    shape = $urandom_range(0, 9);
    k = (shape < 6 || shape == 8) ? plen : $urandom_range(0, plen);
    for (int i = 0; i < k; i++) begin
      u = {8'h00, pchars[8*i +: 8]};
      if (shape == 8 && i == k - 1)
        u = u ^ (($urandom_range(0, 1) == 1) ? 16'h0100 : 16'h0001);
      send_word(u, 1'b0);
    end
    n = (shape == 9) ? $urandom_range(1, 6) : $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: u = UNIT_W'($urandom);
        2: u = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        default: u = UNIT_W'($urandom_range(32, 126));
      endcase
      send_word(u, 1'b0);
    end
    case ($urandom_range(0, 9))
      0: send_word(CH_CR, 1'b1);
      1: begin
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b1);
      end
      2: send_word(UNIT_W'($urandom_range(32, 126)), 1'b1);
      3, 4: send_word(CH_LF, 1'b0);
      5, 6: begin
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
      end
      default: send_word(CH_CR, 1'b0);
    endcase
  endtask

  initial begin
    logic              r_toc;
    logic              r_del;
    logic [LEN_W-1:0]  r_len;
    logic [PFX_W-1:0]  r_chars;
    int                r_eff;
    int                stop_at;

    rst = 1'b1;
    in_valid = 1'b0;
    code_unit = '0;
    end_of_text = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TOC_ENABLE;
    cfg_data = '0;
    items_sent = 0;
    burst_left = 0;
    steady = 1'b0;
    cycle_count = 0;
    stall_tick = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // normalization only, straight out of reset
    send_word(16'hFFFF, 1'b0);
    send_word(CH_LF, 1'b1);

    // deletion off: held prefix goes out once matched
    write_regs(1'b1, 1'b0, 4'd2, 64'h2323);
    send_word(16'h0023, 1'b0);
    send_word(16'h0023, 1'b0);
    send_word(16'h0054, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(16'h0023, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(16'h0023, 1'b0);
    send_word(16'h0023, 1'b1);

    // oversized length, CR and 0xFF in the prefix, upper byte mismatch, dropped LF
    write_regs(1'b1, 1'b1, 4'd15, 64'h4142434445460DFF);
    send_word(16'h00FF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(16'h01FF, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b1);

    // deletion dropped after the prefix is held, entry closed by end of text
    write_regs(1'b1, 1'b1, 4'd1, 64'h2A);
    send_word(16'h002A, 1'b0);
    write_one(REG_DELETE_LINES, 64'd0);
    send_word(16'h0058, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b1);

    // extraction switched off with a held prefix
    write_one(REG_DELETE_LINES, 64'd1);
    send_word(16'h002A, 1'b0);
    write_one(REG_TOC_ENABLE, 64'd0);
    send_word(16'h0059, 1'b1);

    // prefix alone at end of text: no entry, the held prefix goes out as body
    write_one(REG_TOC_ENABLE, 64'd1);
    send_word(16'h002A, 1'b1);

    // zero-length prefix: every nonempty line is an entry
    write_regs(1'b1, 1'b1, 4'd0, 64'd0);
    send_word(16'h005A, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_CR, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      r_toc = ($urandom_range(0, 4) != 0);
      r_del = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: r_len = 4'd0;
        1: r_len = 4'd8;
        2: r_len = 4'd15;
        3: r_len = 4'($urandom_range(9, 14));
        default: r_len = 4'($urandom_range(1, 7));
      endcase
      for (int b = 0; b < 8; b++) begin
        case ($urandom_range(0, 11))
          0: r_chars[8*b +: 8] = 8'hFF;
          1: r_chars[8*b +: 8] = 8'h00;
          2: r_chars[8*b +: 8] = 8'($urandom);
          3: r_chars[8*b +: 8] = (b > 1) ? 8'h0D : 8'h3E;
          4: r_chars[8*b +: 8] = (b > 2) ? 8'h0A : 8'h3D;
          default: r_chars[8*b +: 8] = 8'($urandom_range(33, 126));
        endcase
      end
      if (ph == 0) begin
        r_toc = 1'b1;
        r_len = 4'd8;
        r_chars = '1;
      end else if (ph == 1) begin
        r_toc = 1'b1;
        r_len = 4'd0;
        r_chars = '0;
      end
      r_eff = (r_len > PREFIX_MAX) ? PREFIX_MAX : r_len;
      write_regs(r_toc, r_del, r_len, r_chars);
      steady = ($urandom_range(0, 3) == 0);
      stop_at = items_sent + 31;
      while (items_sent < stop_at) random_line(r_eff, r_chars);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
